// ----- src/mlfq_pkg.sv -----
// Shared types and constants for the multilevel feedback queue scheduler.
package mlfq_pkg;

  localparam int NumLevels = 3;
  localparam int MaxTasks  = 64;
  localparam int LvlW      = 2;
  localparam int IdW       = 6;
  localparam int CntW      = 7;
  localparam int QuantW    = 20;
  localparam int StoreDepth = NumLevels * MaxTasks;
  localparam int StoreAw   = $clog2(StoreDepth);
  localparam int CfgIdxW   = 2;

  typedef enum logic [1:0] {
    KIND_SUBMIT = 2'd0,
    KIND_SELECT = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_BOOST  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_Q0 = 2'd0,
    CFG_Q1 = 2'd1,
    CFG_Q2 = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]        kind;
    logic [IdW-1:0]    task_id;
    logic [QuantW-1:0] elapsed_us;
    logic              completed;
  } req_t;

  typedef struct packed {
    logic            task_valid;
    logic [IdW-1:0]  chosen_task;
    logic [LvlW-1:0] task_level;
    logic            demoted;
    logic            overflow;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_BRD,
    ST_BWR,
    ST_OUT
  } exec_state_e;

endpackage

// ----- src/mlfq_if.sv -----
// Valid/ready channel interfaces for requests and results.
interface mlfq_req_if;
  import mlfq_pkg::*;
  logic valid;
  logic ready;
  logic [1:0]        kind;
  logic [IdW-1:0]    task_id;
  logic [QuantW-1:0] elapsed_us;
  logic              completed;
  modport source (output valid, kind, task_id, elapsed_us, completed, input ready);
  modport sink   (input valid, kind, task_id, elapsed_us, completed, output ready);
endinterface

interface mlfq_rsp_if;
  import mlfq_pkg::*;
  logic valid;
  logic ready;
  logic            task_valid;
  logic [IdW-1:0]  chosen_task;
  logic [LvlW-1:0] task_level;
  logic            demoted;
  logic            overflow;
  modport source (output valid, task_valid, chosen_task, task_level, demoted, overflow,
                  input ready);
  modport sink   (input valid, task_valid, chosen_task, task_level, demoted, overflow,
                  output ready);
endinterface

// ----- src/mlfq_ram.sv -----
// Generic single-port-write, registered-read RAM.
module mlfq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ----- src/mlfq_front.sv -----
// Front end: accepts requests into a two-entry queue.
module mlfq_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  mlfq_req_if.sink        req,
  output mlfq_pkg::req_t  item_o,
  output logic            item_valid_o,
  input  logic            item_take_i
);
  import mlfq_pkg::*;

  req_t     buf_q [2];
  logic     wp_q, rp_q;
  logic [1:0] cnt_q;
  logic     push, pop;

  assign req.ready    = (cnt_q != 2'd2);
  assign push         = req.valid && req.ready;
  assign item_valid_o = (cnt_q != 2'd0);
  assign pop          = item_take_i && item_valid_o;
  assign item_o       = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= '{kind: req.kind, task_id: req.task_id,
                               elapsed_us: req.elapsed_us, completed: req.completed};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- src/mlfq_back.sv -----
// Back end: executes queue operations on the store and level table.
module mlfq_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mlfq_pkg::req_t           item_i,
  input  logic                     item_valid_i,
  output logic                     item_take_o,
  input  logic [mlfq_pkg::QuantW-1:0] quant_i [mlfq_pkg::NumLevels],
  mlfq_rsp_if.source               rsp
);
  import mlfq_pkg::*;

  exec_state_e st_q, st_d;
  req_t        cur_q, cur_d;
  rsp_t        res_q, res_d;
  logic [IdW-1:0]  head_q [NumLevels];
  logic [CntW-1:0] cnt_q  [NumLevels];

  // level table and queue store RAMs
  logic            lt_we;
  logic [IdW-1:0]  lt_waddr, lt_raddr;
  logic [LvlW-1:0] lt_wdata, lt_rdata;
  logic            st_we;
  logic [StoreAw-1:0] st_waddr, st_raddr;
  logic [IdW-1:0]  st_wdata, st_rdata;

  mlfq_ram #(.Width(LvlW), .Depth(MaxTasks)) u_lvl (
    .clk_i, .we_i(lt_we), .waddr_i(lt_waddr), .wdata_i(lt_wdata),
    .raddr_i(lt_raddr), .rdata_o(lt_rdata));
  mlfq_ram #(.Width(IdW), .Depth(StoreDepth)) u_store (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(st_wdata),
    .raddr_i(st_raddr), .rdata_o(st_rdata));

  function automatic logic [StoreAw-1:0] slot(input logic [LvlW-1:0] l,
                                              input logic [IdW-1:0] off);
    slot = StoreAw'(l) * StoreAw'(MaxTasks) + StoreAw'(off);
  endfunction

  // highest-priority (lowest-numbered) non-empty queue
  logic            any_ne;
  logic [LvlW-1:0] sel_l;
  always_comb begin
    any_ne = 1'b0;
    sel_l  = '0;
    for (int i = NumLevels - 1; i >= 0; i--) begin
      if (cnt_q[i] != '0) begin
        any_ne = 1'b1;
        sel_l  = LvlW'(i);
      end
    end
  end

  // tick decision on registered level read
  logic [LvlW-1:0] tl_cur, tl_new;
  logic            tl_dem, full_slice;
  always_comb begin
    tl_cur     = (lt_rdata >= LvlW'(NumLevels)) ? LvlW'(NumLevels - 1) : lt_rdata;
    full_slice = ({1'b0, cur_q.elapsed_us} + 21'd1) >= {1'b0, quant_i[tl_cur]};
    tl_dem     = !cur_q.completed && full_slice && (tl_cur != LvlW'(NumLevels - 1));
    tl_new     = tl_dem ? tl_cur + 1'b1 : tl_cur;
  end

  // first non-empty lower queue, drained by boost
  logic boost_more;
  logic [LvlW-1:0] boost_l;
  always_comb begin
    boost_more = 1'b0;
    boost_l    = '0;
    for (int i = NumLevels - 1; i >= 1; i--) begin
      if (cnt_q[i] != '0) begin
        boost_more = 1'b1;
        boost_l    = LvlW'(i);
      end
    end
  end

  assign item_take_o = (st_q == ST_IDLE);
  assign rsp.valid   = (st_q == ST_OUT);
  assign rsp.task_valid  = res_q.task_valid;
  assign rsp.chosen_task = res_q.chosen_task;
  assign rsp.task_level  = res_q.task_level;
  assign rsp.demoted     = res_q.demoted;
  assign rsp.overflow    = res_q.overflow;

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (item_valid_i) begin
        if (item_i.kind == KIND_BOOST) st_d = boost_more ? ST_BRD : ST_OUT;
        else if (item_i.kind == KIND_TICK) st_d = ST_RD;
        else if (item_i.kind == KIND_SELECT) st_d = any_ne ? ST_WR : ST_OUT;
        else st_d = ST_OUT;
      end
      ST_RD:  st_d = ST_OUT;
      ST_BRD: st_d = ST_BWR;
      ST_BWR: st_d = boost_more ? ST_BRD : ST_OUT;
      ST_WR:  st_d = ST_OUT;  // store read data for select lands here
      ST_OUT: if (rsp.ready) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    lt_we = 1'b0; lt_waddr = item_i.task_id; lt_wdata = '0; lt_raddr = item_i.task_id;
    st_we = 1'b0; st_wdata = item_i.task_id; st_waddr = '0;
    st_raddr = slot(sel_l, head_q[sel_l]);
    unique case (st_q)
      ST_IDLE: if (item_valid_i && item_i.kind == KIND_SUBMIT) begin
        lt_we = 1'b1;
        st_we = (cnt_q[0] != CntW'(MaxTasks));
        st_waddr = slot('0, IdW'(head_q[0] + IdW'(cnt_q[0])));
      end
      ST_RD: if (!cur_q.completed) begin
        lt_we = 1'b1; lt_waddr = cur_q.task_id; lt_wdata = tl_new;
        st_we = (cnt_q[tl_new] != CntW'(MaxTasks));
        st_wdata = cur_q.task_id;
        st_waddr = slot(tl_new, IdW'(head_q[tl_new] + IdW'(cnt_q[tl_new])));
      end
      ST_BRD: st_raddr = slot(boost_l, head_q[boost_l]);
      ST_BWR: begin
        lt_we = 1'b1; lt_waddr = st_rdata; lt_wdata = '0;
        st_we = (cnt_q[0] != CntW'(MaxTasks));
        st_wdata = st_rdata;
        st_waddr = slot('0, IdW'(head_q[0] + IdW'(cnt_q[0])));
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      for (int i = 0; i < NumLevels; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      st_q <= st_d;
      unique case (st_q)
        ST_IDLE: if (item_valid_i) begin
          if (item_i.kind == KIND_SUBMIT) begin
            if (cnt_q[0] != CntW'(MaxTasks)) cnt_q[0] <= cnt_q[0] + 1'b1;
          end else if (item_i.kind == KIND_SELECT && any_ne) begin
            head_q[sel_l] <= head_q[sel_l] + 1'b1;
            cnt_q[sel_l]  <= cnt_q[sel_l] - 1'b1;
          end
        end
        ST_RD: if (!cur_q.completed && cnt_q[tl_new] != CntW'(MaxTasks))
          cnt_q[tl_new] <= cnt_q[tl_new] + 1'b1;
        ST_BRD: begin
          head_q[boost_l] <= head_q[boost_l] + 1'b1;
          cnt_q[boost_l]  <= cnt_q[boost_l] - 1'b1;
        end
        ST_BWR: if (cnt_q[0] != CntW'(MaxTasks)) cnt_q[0] <= cnt_q[0] + 1'b1;
        default: ;
      endcase
    end
  end

  // payload
  always_comb begin
    cur_d = cur_q;
    res_d = res_q;
    case (st_q)
      ST_IDLE: if (item_valid_i) begin
        cur_d = item_i;
        res_d = '0;
        if (item_i.kind == KIND_SUBMIT) begin
          res_d.chosen_task = item_i.task_id;
          res_d.overflow    = (cnt_q[0] == CntW'(MaxTasks));
        end else if (item_i.kind == KIND_SELECT && any_ne) begin
          res_d.task_valid = 1'b1;
          res_d.task_level = sel_l;
        end
      end
      ST_WR: res_d.chosen_task = st_rdata;
      ST_RD: begin
        res_d.chosen_task = cur_q.task_id;
        res_d.task_level  = cur_q.completed ? tl_cur : tl_new;
        res_d.demoted     = tl_dem;
        res_d.overflow    = !cur_q.completed && (cnt_q[tl_new] == CntW'(MaxTasks));
      end
      ST_BWR: if (cnt_q[0] == CntW'(MaxTasks)) res_d.overflow = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    res_q <= res_d;
  end
endmodule

// ----- src/multilevel_feedback_queue_top.sv -----
// Top level of the multilevel feedback queue scheduler.
//
// Channels: req (kind, task_id, elapsed_us, completed) in, rsp (task_valid,
// chosen_task, task_level, demoted, overflow) out, valid/ready handshakes.
// Every request gives exactly one result, in order.
// Config: cfg_we_i writes quantum register cfg_idx_i (0..2); others ignored.
// Write only while no request is in flight.
// Sequence per request: submit and empty select go straight from idle to the
// result; select of a task and tick take an extra state for the RAM read; boost
// adds a read and a write state per entry moved out of queues 1 and 2. The
// back-end sequencer handles one request at a time and takes a new one only
// once the last result has been accepted.
// A two-entry request queue in front keeps req ready while a result waits.
// Reset clears queue heads and counts and loads default quanta
// (2000/4000/8000 us); the store and level table are not cleared.
// When rsp is stalled the result holds and the back end waits; the front
// queue still takes up to two requests.
module multilevel_feedback_queue_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  mlfq_req_if.sink                       req,
  mlfq_rsp_if.source                     rsp,
  input  logic                           cfg_we_i,
  input  logic [mlfq_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mlfq_pkg::QuantW-1:0]    cfg_data_i
);
  import mlfq_pkg::*;

  logic [QuantW-1:0] quant_q [NumLevels];
  req_t item;
  logic item_valid, item_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quant_q[0] <= QuantW'(2000);
      quant_q[1] <= QuantW'(4000);
      quant_q[2] <= QuantW'(8000);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_Q0: quant_q[0] <= cfg_data_i;
        CFG_Q1: quant_q[1] <= cfg_data_i;
        CFG_Q2: quant_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mlfq_front u_front (
    .clk_i, .rst_ni, .req,
    .item_o(item), .item_valid_o(item_valid), .item_take_i(item_take));

  mlfq_back u_back (
    .clk_i, .rst_ni,
    .item_i(item), .item_valid_i(item_valid), .item_take_o(item_take),
    .quant_i(quant_q), .rsp);
endmodule

// ----- tb/multilevel_feedback_queue_top_test.sv -----
// Testbench for the multilevel feedback queue scheduler: directed table plus random phases.
`timescale 1ns / 1ps

module multilevel_feedback_queue_top_test;
  import mlfq_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;  // no register behind it
  localparam logic [QuantW-1:0]  QUANT_MAX  = '1;
  localparam int                 OwedDepth  = 16;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [QuantW-1:0]  cfg_data_i;

  mlfq_req_if req_ch ();
  mlfq_rsp_if rsp_ch ();

  multilevel_feedback_queue_top DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req       (req_ch.sink),
    .rsp       (rsp_ch.source),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Scheduler mirror: queues, level table, quanta.
  logic [IdW-1:0]    sched_store [NumLevels][MaxTasks];
  int                sched_head  [NumLevels];
  int                sched_cnt   [NumLevels];
  logic [LvlW-1:0]   task_lvl    [MaxTasks];
  bit                task_known  [MaxTasks];  // level table entry written
  logic [QuantW-1:0] quantum     [NumLevels];

  // results still owed by the block, oldest at owed_rd
  rsp_t owed_buf [OwedDepth];
  int   owed_wr;
  int   owed_rd;
  int   n_errors;
  int   n_results;
  logic [IdW-1:0] last_pick;  // last task handed out by select
  bit   last_pick_ok;

  typedef struct {
    req_t stim;
    bit   fixed;   // expected value typed in below
    rsp_t want;
  } dir_row_t;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  task automatic report(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d want %0d (result %0d)", what, got, want, n_results);
    n_errors++;
  endtask

  function automatic bit sched_push(input int lv, input logic [IdW-1:0] id);
    if (sched_cnt[lv] >= MaxTasks) return 1'b0;
    sched_store[lv][(sched_head[lv] + sched_cnt[lv]) % MaxTasks] = id;
    sched_cnt[lv]++;
    return 1'b1;
  endfunction

  function automatic logic [IdW-1:0] sched_pop(input int lv);
    logic [IdW-1:0] id;
    id = sched_store[lv][sched_head[lv]];
    sched_head[lv] = (sched_head[lv] + 1) % MaxTasks;
    sched_cnt[lv]--;
    return id;
  endfunction

  // Next scheduler decision for one accepted request.
  function automatic rsp_t schedule(input req_t r);
    rsp_t o;
    int   cur;
    logic [IdW-1:0] id;
    o = '0;
    case (kind_e'(r.kind))
      KIND_SUBMIT: begin
        task_lvl[r.task_id] = '0;
        task_known[r.task_id] = 1'b1;
        o.overflow = !sched_push(0, r.task_id);
        o.chosen_task = r.task_id;
      end
      KIND_SELECT: begin
        for (int q = 0; q < NumLevels; q++) begin
          if (!o.task_valid && sched_cnt[q] != 0) begin
            o.task_valid = 1'b1;
            o.chosen_task = sched_pop(q);
            o.task_level = LvlW'(q);
          end
        end
      end
      KIND_TICK: begin
        cur = int'(task_lvl[r.task_id]);
        if (cur >= NumLevels) cur = NumLevels - 1;
        o.chosen_task = r.task_id;
        if (!r.completed) begin
          // full slice: elapsed + 1 >= quantum, no wrap
          if ({1'b0, r.elapsed_us} + 1 >= {1'b0, quantum[cur]} && cur < NumLevels - 1) begin
            cur++;
            o.demoted = 1'b1;
          end
          task_lvl[r.task_id] = LvlW'(cur);
          o.overflow = !sched_push(cur, r.task_id);
        end
        o.task_level = LvlW'(cur);
      end
      default: begin
        // boost: lower queues drain into level 0 in level then FIFO order
        for (int q = 1; q < NumLevels; q++) begin
          while (sched_cnt[q] != 0) begin
            id = sched_pop(q);
            task_lvl[id] = '0;
            if (!sched_push(0, id)) o.overflow = 1'b1;
          end
        end
      end
    endcase
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Send one request; the expectation is queued at the accepting edge.
  task automatic send_req(input req_t r, input bit fixed, input rsp_t want);
    int   gap;
    rsp_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.kind       <= r.kind;
    req_ch.task_id    <= r.task_id;
    req_ch.elapsed_us <= r.elapsed_us;
    req_ch.completed  <= r.completed;
    do @(posedge clk_i); while (!req_ch.ready);
    pred = schedule(r);
    if (kind_e'(r.kind) == KIND_SELECT && pred.task_valid) begin
      last_pick = pred.chosen_task;
      last_pick_ok = 1'b1;
    end
    owed_buf[owed_wr % OwedDepth] = fixed ? want : pred;
    owed_wr++;
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (owed_wr != owed_rd) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_quanta(input logic [QuantW-1:0] q0, input logic [QuantW-1:0] q1,
                              input logic [QuantW-1:0] q2);
    logic [QuantW-1:0] v [NumLevels];
    v = '{q0, q1, q2};
    for (int i = 0; i < NumLevels; i++) begin
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CfgIdxW'(i);
      cfg_data_i <= v[i];
      quantum[i] = v[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Elapsed time around the task's quantum, plus extremes.
  function automatic logic [QuantW-1:0] pick_elapsed(input logic [QuantW-1:0] q);
    case ($urandom_range(5))
      0: return '0;
      1: return QUANT_MAX;
      2: return (q == 0) ? '0 : q - 1;
      3: return (q < 2) ? '0 : q - 2;
      4: return q;
      default: return QuantW'($urandom_range(QUANT_MAX));
    endcase
  endfunction

  // mode 0 mixed, 1 flood with submits, 2 drain by select, 3 run loop
  function automatic req_t rand_req(input int mode);
    req_t r;
    int   w;
    int   lv;
    bit   any;
    r = '0;
    r.task_id = IdW'($urandom_range(MaxTasks - 1));
    r.elapsed_us = QuantW'($urandom_range(QUANT_MAX));
    r.completed = 1'($urandom_range(1));
    w = $urandom_range(99);
    case (mode)
      1: r.kind = (w < 80) ? KIND_SUBMIT : (w < 90) ? KIND_TICK : (w < 95) ? KIND_BOOST
                                                                 : KIND_SELECT;
      2: r.kind = (w < 70) ? KIND_SELECT : (w < 85) ? KIND_TICK : (w < 92) ? KIND_BOOST
                                                                 : KIND_SUBMIT;
      3: r.kind = (w < 40) ? KIND_SELECT : (w < 85) ? KIND_TICK : (w < 92) ? KIND_SUBMIT
                                                                 : KIND_BOOST;
      default: r.kind = kind_e'(w % 4);
    endcase
    if (kind_e'(r.kind) == KIND_TICK) begin
      any = 1'b0;
      foreach (task_known[i]) any |= task_known[i];
      if (!any) begin
        r.kind = KIND_SUBMIT;
      end else begin
        if (last_pick_ok && $urandom_range(99) < 60) begin
          r.task_id = last_pick;
        end else begin
          while (!task_known[r.task_id]) r.task_id = IdW'($urandom_range(MaxTasks - 1));
        end
        r.completed = ($urandom_range(99) < 15);
        lv = int'(task_lvl[r.task_id]);
        r.elapsed_us = pick_elapsed(quantum[lv]);
      end
    end
    return r;
  endfunction

  // Result side: random stalls plus one long hold-off to fill the block.
  initial begin
    int  stall_left;
    bit  held;
    rsp_t got;
    rsp_t want;
    stall_left = 0;
    held = 1'b0;
    rsp_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = '{rsp_ch.task_valid, rsp_ch.chosen_task, rsp_ch.task_level,
                rsp_ch.demoted, rsp_ch.overflow};
        n_results++;
        if (owed_wr == owed_rd) begin
          report("unexpected result", got.chosen_task, 0);
        end else begin
          want = owed_buf[owed_rd % OwedDepth];
          owed_rd++;
          if (got.task_valid !== want.task_valid)
            report("task_valid", got.task_valid, want.task_valid);
          if (got.chosen_task !== want.chosen_task)
            report("chosen_task", got.chosen_task, want.chosen_task);
          if (got.task_level !== want.task_level)
            report("task_level", got.task_level, want.task_level);
          if (got.demoted !== want.demoted)
            report("demoted", got.demoted, want.demoted);
          if (got.overflow !== want.overflow)
            report("overflow", got.overflow, want.overflow);
        end
      end
      if (!held && n_results == 400) begin
        held = 1'b1;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if ($urandom_range(99) < 15 && !(n_results > 1200 && n_results < 1300))
          stall_left = pick_gap();
      end
    end
  end

  // Stimulus.
  initial begin
    dir_row_t dir_tab [$];
    logic [QuantW-1:0] qset [6][NumLevels];
    int mode;
    rsp_t none;

    none = '0;
    n_errors = 0;
    n_results = 0;
    owed_wr = 0;
    owed_rd = 0;
    last_pick = '0;
    last_pick_ok = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    req_ch.valid = 1'b0;
    req_ch.kind = KIND_SUBMIT;
    req_ch.task_id = '0;
    req_ch.elapsed_us = '0;
    req_ch.completed = 1'b0;
    foreach (sched_head[i]) begin
      sched_head[i] = 0;
      sched_cnt[i] = 0;
    end
    foreach (task_lvl[i]) begin
      task_lvl[i] = '0;
      task_known[i] = 1'b0;
    end
    quantum = '{20'd2000, 20'd4000, 20'd8000};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // stim: kind, task, elapsed, completed / want: valid, task, level, demoted, ovf
    dir_tab = '{
      '{'{KIND_SELECT, 6'd0,  20'd0,    1'b0}, 1, '{1'b0, 6'd0,  2'd0, 1'b0, 1'b0}},
      '{'{KIND_SUBMIT, 6'd63, 20'd0,    1'b0}, 1, '{1'b0, 6'd63, 2'd0, 1'b0, 1'b0}},
      '{'{KIND_SUBMIT, 6'd0,  QUANT_MAX, 1'b1}, 1, '{1'b0, 6'd0, 2'd0, 1'b0, 1'b0}},
      '{'{KIND_SUBMIT, 6'd42, 20'd0,    1'b0}, 0, none},
      '{'{KIND_SUBMIT, 6'd21, 20'd0,    1'b0}, 0, none},
      '{'{KIND_SELECT, 6'd0,  20'd0,    1'b0}, 1, '{1'b1, 6'd63, 2'd0, 1'b0, 1'b0}},
      // one short of the level-0 slice: stays put
      '{'{KIND_TICK,   6'd63, 20'd1998, 1'b0}, 1, '{1'b0, 6'd63, 2'd0, 1'b0, 1'b0}},
      // exactly used up: one level down
      '{'{KIND_TICK,   6'd63, 20'd1999, 1'b0}, 1, '{1'b0, 6'd63, 2'd1, 1'b1, 1'b0}},
      '{'{KIND_TICK,   6'd63, QUANT_MAX, 1'b0}, 1, '{1'b0, 6'd63, 2'd2, 1'b1, 1'b0}},
      // already at the lowest level
      '{'{KIND_TICK,   6'd63, QUANT_MAX, 1'b0}, 1, '{1'b0, 6'd63, 2'd2, 1'b0, 1'b0}},
      // finished task is not requeued
      '{'{KIND_TICK,   6'd0,  QUANT_MAX, 1'b1}, 1, '{1'b0, 6'd0,  2'd0, 1'b0, 1'b0}},
      '{'{KIND_TICK,   6'd42, 20'd5,    1'b0}, 0, none},
      '{'{KIND_BOOST,  6'd0,  20'd0,    1'b0}, 1, '{1'b0, 6'd0,  2'd0, 1'b0, 1'b0}},
      '{'{KIND_SELECT, 6'd0,  20'd0,    1'b0}, 0, none},
      '{'{KIND_SELECT, 6'd0,  20'd0,    1'b0}, 0, none},
      '{'{KIND_SELECT, 6'd0,  20'd0,    1'b0}, 0, none},
      '{'{KIND_SELECT, 6'd0,  20'd0,    1'b0}, 0, none},
      '{'{KIND_SELECT, 6'd0,  20'd0,    1'b0}, 0, none},
      '{'{KIND_SELECT, 6'd0,  20'd0,    1'b0}, 0, none},
      '{'{KIND_SELECT, 6'd0,  20'd0,    1'b0}, 0, none},
      '{'{KIND_SELECT, 6'd0,  20'd0,    1'b0}, 0, none},
      '{'{KIND_SELECT, 6'd0,  20'd0,    1'b0}, 1, '{1'b0, 6'd0,  2'd0, 1'b0, 1'b0}}
    };
    foreach (dir_tab[i]) send_req(dir_tab[i].stim, dir_tab[i].fixed, dir_tab[i].want);
    wait_drained();

    // extremes, zero quantum (always used up), then mixed settings
    qset = '{'{20'd1, 20'd1, 20'd1},
             '{20'd0, QUANT_MAX, 20'd5},
             '{QUANT_MAX, QUANT_MAX, QUANT_MAX},
             '{20'd100, 20'd300, 20'd1000},
             '{20'd2000, 20'd4000, 20'd8000},
             '{20'd0, 20'd0, 20'd0}};
    qset[5][0] = QuantW'($urandom_range(QUANT_MAX, 1));
    qset[5][1] = QuantW'($urandom_range(5000));
    qset[5][2] = QuantW'($urandom_range(QUANT_MAX));

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) begin
        // the unused index must leave the quanta alone
        @(posedge clk_i);
        cfg_we_i   <= 1'b1;
        cfg_idx_i  <= CFG_UNUSED;
        cfg_data_i <= '0;
      end
      write_quanta(qset[ph][0], qset[ph][1], qset[ph][2]);
      mode = 0;
      for (int n = 0; n < 255; n++) begin
        if (n % 50 == 0) mode = $urandom_range(3);
        // occasional flood long enough to overflow level 0
        if (n == 100 && ph % 2 == 0) begin
          for (int k = 0; k < 70; k++)
            send_req(rand_req(1), 1'b0, none);
        end
        send_req(rand_req(mode), 1'b0, none);
      end
      wait_drained();
    end

    if (n_errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
src/mlfq_pkg.sv
src/mlfq_if.sv
src/mlfq_ram.sv
src/mlfq_front.sv
src/mlfq_back.sv
src/multilevel_feedback_queue_top.sv
tb/multilevel_feedback_queue_top_test.sv
